// ===== hw/rtl/cabm_pkg.sv =====
// Shared types and constants for the cyclic asynchronous buffer manager.
// No dependencies.
`timescale 1ns / 1ps

package cabm_pkg;

  localparam int unsigned NUM_BUFFERS_DEF = 16;
  localparam int unsigned RDR_W           = 8;
  localparam logic [RDR_W-1:0] RDR_MAX    = '1;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_PUT     = 2'd1,
    OP_GET     = 2'd2,
    OP_UNGET   = 2'd3
  } cabm_op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_SATURATED = 2'd3
  } cabm_status_e;

endpackage

// ===== hw/rtl/cabm_store.sv =====
// Link and reader-count memories, registered synchronous read, with per-entry
// valid bits standing in for the reset contents. Depends on cabm_pkg.
`timescale 1ns / 1ps

module cabm_store import cabm_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = NUM_BUFFERS_DEF,
  localparam int unsigned IDX_W = $clog2(NUM_BUFFERS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [IDX_W-1:0] link_raddr_i,
  output logic [IDX_W-1:0] link_rdata_o,
  input  logic [IDX_W-1:0] cnt_raddr_i,
  output logic [RDR_W-1:0] cnt_rdata_o,
  input  logic             link_we_i,
  input  logic [IDX_W-1:0] link_waddr_i,
  input  logic [IDX_W-1:0] link_wdata_i,
  input  logic             cnt_we_i,
  input  logic [IDX_W-1:0] cnt_waddr_i,
  input  logic [RDR_W-1:0] cnt_wdata_i
);

  logic [IDX_W-1:0]   link_mem [NUM_BUFFERS];
  logic [RDR_W-1:0]   cnt_mem  [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] link_vld_q, cnt_vld_q;

  logic [IDX_W-1:0] link_mem_q, link_raddr_q, link_dflt;
  logic [RDR_W-1:0] cnt_mem_q;
  logic             link_rvld_q, cnt_rvld_q;

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (cnt_we_i) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    if (re_i) begin
      link_mem_q   <= link_mem[link_raddr_i];
      cnt_mem_q    <= cnt_mem[cnt_raddr_i];
      link_raddr_q <= link_raddr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q  <= '0;
      cnt_vld_q   <= '0;
      link_rvld_q <= 1'b0;
      cnt_rvld_q  <= 1'b0;
    end else begin
      if (re_i) begin
        link_rvld_q <= link_vld_q[link_raddr_i];
        cnt_rvld_q  <= cnt_vld_q[cnt_raddr_i];
      end
      if (link_we_i) begin
        link_vld_q[link_waddr_i] <= 1'b1;
      end
      if (cnt_we_i) begin
        cnt_vld_q[cnt_waddr_i] <= 1'b1;
      end
    end
  end

  // untouched link entries hold (i + 1) mod N
  assign link_dflt = (link_raddr_q == IDX_W'(NUM_BUFFERS - 1)) ? '0 : link_raddr_q + 1'b1;

  assign link_rdata_o = link_rvld_q ? link_mem_q : link_dflt;
  assign cnt_rdata_o  = cnt_rvld_q ? cnt_mem_q : '0;

endmodule

// ===== hw/rtl/cyclic_async_buffer_manager.sv =====
// Cyclic asynchronous buffer manager: free list, reader counts, latest index.
// The result strobe is high in the cycle after start is taken.
// A new word waits for the read then write-back of the link and reader-count
// memories of the last one. busy_o is high during the write-back cycle.
// Reset: buffer 0 latest, buffers 1..N-1 free; ready to accept at once.
// The receiver cannot stall: results are held for exactly one cycle.
`timescale 1ns / 1ps

module cyclic_async_buffer_manager import cabm_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] opcode_i,
  input  logic [3:0] buffer_index_i,
  output logic       valid_o,
  output logic [3:0] result_index_o,
  output logic [1:0] status_o,
  output logic [3:0] free_buffers_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BUFFERS);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  logic [IDX_W-1:0] latest_q, latest_d, head_q, head_d, total_q, total_d;
  cabm_op_e         op_q;
  logic [IDX_W-1:0] b_q;
  logic             in_range_q;

  logic             accept;
  logic [31:0]      b_wide;
  logic [IDX_W-1:0] b_in;
  logic             in_range_in;

  logic [IDX_W-1:0] link_rdata;
  logic [RDR_W-1:0] cnt_rdata;
  logic             link_we, cnt_we, cnt_we_exec;
  logic [IDX_W-1:0] link_waddr, link_wdata, cnt_waddr;
  logic [RDR_W-1:0] cnt_wdata;

  logic [IDX_W-1:0] res;
  cabm_status_e     stat;
  logic             push;
  logic [IDX_W-1:0] push_idx;
  logic [31:0]      res_wide, total_wide;

  assign accept      = start_i && (state_q == S_IDLE);
  assign b_wide      = 32'(buffer_index_i);
  assign b_in        = b_wide[IDX_W-1:0];
  assign in_range_in = b_wide < NUM_BUFFERS;

  cabm_store #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_store (
    .clk_i,
    .rst_ni,
    .re_i         (accept),
    .link_raddr_i (head_q),
    .link_rdata_o (link_rdata),
    .cnt_raddr_i  ((cabm_op_e'(opcode_i) == OP_UNGET) ? b_in : latest_q),
    .cnt_rdata_o  (cnt_rdata),
    .link_we_i    (link_we),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .cnt_we_i     (cnt_we_exec),
    .cnt_waddr_i  (cnt_waddr),
    .cnt_wdata_i  (cnt_wdata)
  );

  always_comb begin
    res       = '0;
    stat      = STAT_OK;
    latest_d  = latest_q;
    head_d    = head_q;
    total_d   = total_q;
    push      = 1'b0;
    push_idx  = latest_q;
    cnt_we    = 1'b0;
    cnt_waddr = latest_q;
    cnt_wdata = cnt_rdata;
    case (op_q)
      OP_RESERVE: begin
        if (total_q == '0) begin
          stat = STAT_EMPTY;
        end else begin
          res     = head_q;
          head_d  = link_rdata;
          total_d = total_q - 1'b1;
        end
      end
      OP_PUT: begin
        if (in_range_q && b_q != latest_q) begin
          push     = (cnt_rdata == '0);
          push_idx = latest_q;
          latest_d = b_q;
        end
      end
      OP_GET: begin
        res = latest_q;
        if (cnt_rdata == RDR_MAX) begin
          stat = STAT_SATURATED;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata + 1'b1;
        end
      end
      OP_UNGET: begin
        if (in_range_q) begin
          if (cnt_rdata == '0) begin
            stat = STAT_UNDERFLOW;
          end else begin
            cnt_we    = 1'b1;
            cnt_waddr = b_q;
            cnt_wdata = cnt_rdata - 1'b1;
            push      = (cnt_rdata == RDR_W'(1)) && (b_q != latest_q);
            push_idx  = b_q;
          end
        end
      end
      default: ;
    endcase
    if (push) begin
      head_d = push_idx;
      if (total_q != IDX_W'(NUM_BUFFERS - 1)) begin
        total_d = total_q + 1'b1;
      end
    end
  end

  assign link_we    = (state_q == S_EXEC) && push;
  assign link_waddr = push_idx;
  assign link_wdata = head_q;

  assign busy_o         = (state_q == S_EXEC);
  assign valid_o        = (state_q == S_EXEC);
  assign res_wide       = 32'(res);
  assign total_wide     = 32'(total_d);
  assign result_index_o = res_wide[3:0];
  assign status_o       = stat;
  assign free_buffers_o = total_wide[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      latest_q <= '0;
      head_q   <= IDX_W'(1 % NUM_BUFFERS);
      total_q  <= IDX_W'(NUM_BUFFERS - 1);
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q  <= S_IDLE;
          latest_q <= latest_d;
          head_q   <= head_d;
          total_q  <= total_d;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= cabm_op_e'(opcode_i);
      b_q        <= b_in;
      in_range_q <= in_range_in;
    end
  end

  // gate the store's write port to the write-back cycle
  assign cnt_we_exec = (state_q == S_EXEC) && cnt_we;

endmodule

// ===== tb/tb_cyclic_async_buffer_manager.sv =====
// Testbench for cyclic_async_buffer_manager: directed then mostly well-formed random
// reserve/put/get/unget traffic, each result word checked against a built-in model.
// Depends on cabm_pkg and the cyclic_async_buffer_manager RTL.
`timescale 1ns / 1ps

module tb_cyclic_async_buffer_manager;
  import cabm_pkg::*;

  localparam int unsigned NBUF        = NUM_BUFFERS_DEF;
  localparam int unsigned STALL_LIMIT = 400;
  localparam int unsigned RAND_ROUNDS = 1050;
  localparam int unsigned QUIET_TAIL  = 250;

  typedef struct packed {
    logic [3:0]   res_index;
    cabm_status_e status;
    logic [3:0]   free_cnt;
  } cab_word_t;

  class cab_index_scoreboard;
    logic [3:0]       link_q[NBUF];
    logic [RDR_W-1:0] readers_q[NBUF];
    logic [3:0]       latest_q;
    logic [3:0]       head_q;
    logic [3:0]       free_q;
    cab_word_t        pending_words[$];
    int unsigned      mismatches;

    function new();
      for (int i = 0; i < NBUF; i++) begin
        link_q[i]    = 4'((i + 1) % NBUF);
        readers_q[i] = '0;
      end
      latest_q   = '0;
      head_q     = 4'(1 % NBUF);
      free_q     = 4'(NBUF - 1);
      mismatches = 0;
    endfunction

    function void release_buffer(logic [3:0] b);
      link_q[b] = head_q;
      head_q    = b;
      if (int'(free_q) < NBUF - 1) free_q++;
    endfunction

    function cab_word_t note_command(cabm_op_e op, logic [3:0] b);
      cab_word_t w;
      w.res_index = '0;
      w.status    = STAT_OK;
      case (op)
        OP_RESERVE: begin
          if (free_q == 0) begin
            w.status = STAT_EMPTY;
          end else begin
            w.res_index = head_q;
            head_q      = link_q[head_q];
            free_q--;
          end
        end
        OP_PUT: begin
          if (int'(b) < NBUF && b != latest_q) begin
            if (readers_q[latest_q] == 0) release_buffer(latest_q);
            latest_q = b;
          end
        end
        OP_GET: begin
          w.res_index = latest_q;
          if (readers_q[latest_q] == RDR_MAX) w.status = STAT_SATURATED;
          else readers_q[latest_q]++;
        end
        default: begin
          if (int'(b) < NBUF) begin
            if (readers_q[b] == 0) begin
              w.status = STAT_UNDERFLOW;
            end else begin
              readers_q[b]--;
              if (readers_q[b] == 0 && b != latest_q) release_buffer(b);
            end
          end
        end
      endcase
      w.free_cnt = free_q;
      pending_words.push_back(w);
      return w;
    endfunction

    task report_mismatch(string what, logic [3:0] got, logic [3:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_word(logic [3:0] res_index, logic [1:0] status, logic [3:0] free_cnt);
      cab_word_t w;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, result_index", res_index, 4'h0);
      end else begin
        w = pending_words.pop_front();
        if (res_index !== w.res_index) report_mismatch("result_index", res_index, w.res_index);
        if (status !== w.status) report_mismatch("status", 4'(status), 4'(w.status));
        if (free_cnt !== w.free_cnt) report_mismatch("free_buffers", free_cnt, w.free_cnt);
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  opcode_i;
  logic [3:0]  buffer_index_i;
  logic        valid_o;
  logic [3:0]  result_index_o;
  logic [1:0]  status_o;
  logic [3:0]  free_buffers_o;

  cab_index_scoreboard index_sb;
  logic [3:0]          held_q[$];
  logic [3:0]          reserved_q[$];
  bit                  idle_on;
  int unsigned         quiet_cycles = 0;

  cyclic_async_buffer_manager #(
    .NUM_BUFFERS(NBUF)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .buffer_index_i(buffer_index_i),
    .valid_o       (valid_o),
    .result_index_o(result_index_o),
    .status_o      (status_o),
    .free_buffers_o(free_buffers_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) index_sb.check_word(result_index_o, status_o, free_buffers_o);
      if (valid_o || (start_i && !busy_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the word
  task automatic issue_word(input cabm_op_e op, input logic [3:0] b, output cab_word_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    opcode_i       <= op;
    buffer_index_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    w = index_sb.note_command(op, b);
  endtask

  task automatic random_round(bit tidy);
    cab_word_t   w;
    int unsigned k;
    logic [3:0]  b;
    if (!tidy || $urandom_range(0, 99) < 15) begin
      issue_word(cabm_op_e'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), w);
    end else if ($urandom_range(0, 1) == 0) begin
      if (reserved_q.size() != 0 && $urandom_range(0, 2) == 0) begin
        issue_word(OP_PUT, reserved_q.pop_front(), w);
      end else begin
        issue_word(OP_RESERVE, 4'($urandom), w);
        if (w.status == STAT_OK) begin
          if ($urandom_range(0, 3) != 0) issue_word(OP_PUT, w.res_index, w);
          else reserved_q.push_back(w.res_index);
        end
      end
    end else if (held_q.size() < 2 || (held_q.size() < 10 && $urandom_range(0, 1) == 0)) begin
      issue_word(OP_GET, 4'($urandom), w);
      if (w.status == STAT_OK) held_q.push_back(w.res_index);
    end else begin
      k = $urandom_range(0, held_q.size() - 1);
      b = held_q[k];
      held_q.delete(k);
      issue_word(OP_UNGET, b, w);
    end
  endtask

  // drive the latest buffer's reader count into saturation, then back through zero
  task automatic saturate_readers();
    cab_word_t  w;
    logic [3:0] lt;
    repeat (260) issue_word(OP_GET, 4'($urandom), w);
    lt = w.res_index;
    do issue_word(OP_UNGET, lt, w); while (w.status == STAT_OK);
    for (int i = held_q.size() - 1; i >= 0; i--) begin
      if (held_q[i] == lt) held_q.delete(i);
    end
  endtask

  initial begin
    cab_word_t w;
    index_sb       = new();
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    opcode_i       = OP_RESERVE;
    buffer_index_i = '0;
    idle_on        = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_word(OP_GET, 4'hF, w);
    issue_word(OP_UNGET, 4'h0, w);
    issue_word(OP_UNGET, 4'h0, w);
    repeat (NBUF - 1) begin
      issue_word(OP_RESERVE, 4'h0, w);
      reserved_q.push_back(w.res_index);
    end
    issue_word(OP_RESERVE, 4'hF, w);
    issue_word(OP_PUT, reserved_q.pop_back(), w);
    issue_word(OP_PUT, w.res_index == 0 ? index_sb.latest_q : index_sb.latest_q, w);
    issue_word(OP_GET, 4'h0, w);
    issue_word(OP_PUT, reserved_q.pop_back(), w);
    issue_word(OP_UNGET, 4'hF, w);
    issue_word(OP_RESERVE, 4'h0, w);
    if (w.status == STAT_OK) reserved_q.push_back(w.res_index);

    for (int n = 0; n < RAND_ROUNDS; n++) begin
      if (n % 150 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (n >= RAND_ROUNDS - QUIET_TAIL) idle_on = 1'b0;
      if (n == 600) saturate_readers();
      random_round(1'b1);
    end

    start_i <= 1'b0;
    while (index_sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (index_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
